FILE: sv/wsjd_pkg.sv
package wsjd_pkg;

  localparam int MAX_WORKERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [15:0] PENDING_MAX = 16'hFFFF;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_FETCH    = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic take;   // latch the incoming transaction
    logic exec;   // update queues and pending count
    logic load;   // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/work_stealing_job_dispatcher.sv
// Channel   Direction  Handshake               Payload
// in_       slave      in_tvalid / in_tready   tuser: cmd; tdata: worker, job_handle
// out_      master     out_tvalid / out_tready tuser: status; tdata: result fields
// cfg_      write      cfg_wr_en               active_workers
//
// Every transaction passes through two states: S_EXEC updates the queue state
// and writes or reads the job store, S_FIN moves the result into the output
// register, where the next transaction is taken. Reset (rst_n low,
// synchronous) empties all queues and clears the pending count; the job store
// is not cleared. A stalled output holds its result; one more transaction is
// taken and executed, then in_tready stays low until the output is taken.
module work_stealing_job_dispatcher import wsjd_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,    // active_workers
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,       // worker[2:0], job_handle[18:3], zero pad
  input  logic [1:0]  in_tuser,       // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,      // job_out[15:0], source_queue[18:16],
                                      // stolen[19], pending_count[35:20],
                                      // all_done[36], zero pad
  output logic [1:0]  out_tuser       // status[1:0]
);

  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  logic [1:0]  res_status;
  logic [15:0] res_job;
  logic [2:0]  res_src;
  logic        res_stolen;
  logic [15:0] res_pending;
  logic        res_all_done;

  wsjd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsjd_dp #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_cmd     (in_tuser),
    .item_worker  (in_tdata[2:0]),
    .item_handle  (in_tdata[18:3]),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .res_status   (res_status),
    .res_job      (res_job),
    .res_src      (res_src),
    .res_stolen   (res_stolen),
    .res_pending  (res_pending),
    .res_all_done (res_all_done),
    .cmd          (cmd),
    .sts          (sts)
  );

  assign out_tuser = res_status;
  assign out_tdata = {3'b000, res_all_done, res_pending, res_stolen, res_src, res_job};

endmodule

FILE: sv/wsjd_ram.sv
module wsjd_ram import wsjd_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/wsjd_ctrl.sv
module wsjd_ctrl import wsjd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // The next transaction may be taken in the same cycle the result leaves.
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.take  = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/wsjd_dp.sv
module wsjd_dp import wsjd_pkg::*; #(
  parameter int MAX_WORKERS = MAX_WORKERS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic [1:0]  item_cmd,
  input  logic [2:0]  item_worker,
  input  logic [15:0] item_handle,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [1:0]  res_status,
  output logic [15:0] res_job,
  output logic [2:0]  res_src,
  output logic        res_stolen,
  output logic [15:0] res_pending,
  output logic        res_all_done,
  input  ctl_cmd_t    cmd,
  output dp_sts_t     sts
);

  localparam int QW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MAX_WORKERS * QUEUE_DEPTH);
  localparam logic [SW:0] QD = (SW + 1)'(QUEUE_DEPTH);

  logic [3:0]    active_r;
  logic [1:0]    cmd_r;
  logic [2:0]    worker_r;
  logic [15:0]   handle_r;
  logic [QW-1:0] place_r, place_nxt;
  logic [15:0]   pend_r, pend_nxt;
  logic [SW-1:0] head_r [MAX_WORKERS];
  logic [FW-1:0] fill_r [MAX_WORKERS];

  logic [1:0]    rs_status_r, rs_status_nxt;
  logic [2:0]    rs_src_r, rs_src_nxt;
  logic          rs_stolen_r, rs_stolen_nxt;
  logic          rs_ram_r, rs_ram_nxt;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [15:0]   out_job_r;
  logic [2:0]    out_src_r;
  logic          out_stolen_r;
  logic [15:0]   out_pend_r;

  logic [3:0]    cnt;
  logic [QW-1:0] q_place, place_adv, wq, victim, hi_v, lo_v, sel_q;
  logic          worker_ok, own_ne, hi_found, lo_found, steal_ok;
  logic [MAX_WORKERS-1:0] nonempty;
  logic [SW-1:0] h, slot;
  logic [FW-1:0] f;
  logic [SW:0]   sum_new, sum_m1, slot_push, slot_newest, head_inc;
  logic          is_full;
  logic          fill_up, fill_dn, head_up;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;

  always_comb begin
    if (active_r == 4'd0) begin
      cnt = 4'd1;
    end else if (32'(active_r) > MAX_WORKERS) begin
      cnt = 4'(MAX_WORKERS);
    end else begin
      cnt = active_r;
    end
  end

  assign q_place   = (32'(place_r) < 32'(cnt)) ? place_r : '0;
  assign place_adv = (32'(q_place) + 1 >= 32'(cnt)) ? '0 : q_place + QW'(1);
  assign wq        = QW'(worker_r);
  assign worker_ok = 32'(worker_r) < 32'(cnt);

  always_comb begin
    for (int j = 0; j < MAX_WORKERS; j++) begin
      nonempty[j] = (fill_r[j] != '0);
    end
  end

  assign own_ne = nonempty[wq];

  // Ring order from the next worker: first the active queues above the
  // asking worker, then the ones below it, each lowest index first.
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_v     = '0;
    lo_v     = '0;
    for (int j = 0; j < MAX_WORKERS; j++) begin
      if (!hi_found && nonempty[j] && (j > 32'(worker_r)) && (j < 32'(cnt))) begin
        hi_found = 1'b1;
        hi_v     = QW'(j);
      end
      if (!lo_found && nonempty[j] && (j < 32'(worker_r))) begin
        lo_found = 1'b1;
        lo_v     = QW'(j);
      end
    end
  end

  assign victim   = hi_found ? hi_v : lo_v;
  assign steal_ok = worker_ok && !own_ne && (hi_found || lo_found);

  always_comb begin
    if (cmd_r == CMD_SCHEDULE) begin
      sel_q = q_place;
    end else if (own_ne) begin
      sel_q = wq;
    end else begin
      sel_q = victim;
    end
  end

  assign h = head_r[sel_q];
  assign f = fill_r[sel_q];

  assign sum_new     = {1'b0, h} + (SW + 1)'(f);
  assign sum_m1      = sum_new - (SW + 1)'(1);
  assign slot_push   = (sum_new >= QD) ? sum_new - QD : sum_new;
  assign slot_newest = (sum_m1 >= QD) ? sum_m1 - QD : sum_m1;
  assign head_inc    = ({1'b0, h} + (SW + 1)'(1) == QD) ? '0 : {1'b0, h} + (SW + 1)'(1);
  assign is_full     = (32'(f) >= QUEUE_DEPTH);

  always_comb begin
    rs_status_nxt = ST_OK;
    rs_src_nxt    = '0;
    rs_stolen_nxt = 1'b0;
    rs_ram_nxt    = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    slot          = '0;
    fill_up       = 1'b0;
    fill_dn       = 1'b0;
    head_up       = 1'b0;
    pend_nxt      = pend_r;
    place_nxt     = place_r;
    case (cmd_r)
      CMD_SCHEDULE: begin
        place_nxt  = place_adv;
        rs_src_nxt = 3'(q_place);
        if (is_full) begin
          rs_status_nxt = ST_FULL;
        end else begin
          ram_we  = cmd.exec;
          slot    = slot_push[SW-1:0];
          fill_up = 1'b1;
          if (pend_r != PENDING_MAX) begin
            pend_nxt = pend_r + 16'd1;
          end
        end
      end
      CMD_FETCH: begin
        rs_status_nxt = ST_EMPTY;
        rs_src_nxt    = worker_r;
        if (worker_ok && own_ne) begin
          ram_re        = cmd.exec;
          slot          = slot_newest[SW-1:0];
          fill_dn       = 1'b1;
          rs_status_nxt = ST_OK;
          rs_ram_nxt    = 1'b1;
        end else if (steal_ok) begin
          ram_re        = cmd.exec;
          slot          = h;
          head_up       = 1'b1;
          fill_dn       = 1'b1;
          rs_src_nxt    = 3'(victim);
          rs_stolen_nxt = 1'b1;
          rs_status_nxt = ST_OK;
          rs_ram_nxt    = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (pend_r != 16'd0) begin
          pend_nxt = pend_r - 16'd1;
        end
      end
      default: begin
        rs_status_nxt = ST_OK;
      end
    endcase
  end

  assign ram_addr = AW'(32'(sel_q) * QUEUE_DEPTH + 32'(slot));

  wsjd_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WORKERS * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (handle_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 4'd1;
    end else if (cfg_wr_en) begin
      active_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_r    <= item_cmd;
      worker_r <= item_worker;
      handle_r <= item_handle;
    end
    if (cmd.exec) begin
      rs_status_r <= rs_status_nxt;
      rs_src_r    <= rs_src_nxt;
      rs_stolen_r <= rs_stolen_nxt;
      rs_ram_r    <= rs_ram_nxt;
    end
    if (cmd.load) begin
      out_status_r <= rs_status_r;
      out_job_r    <= rs_ram_r ? ram_rdata : 16'd0;
      out_src_r    <= rs_src_r;
      out_stolen_r <= rs_stolen_r;
      out_pend_r   <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_WORKERS; j++) begin
        head_r[j] <= '0;
        fill_r[j] <= '0;
      end
    end else begin
      if (cmd.exec) begin
        place_r <= place_nxt;
        pend_r  <= pend_nxt;
        if (fill_up) begin
          fill_r[sel_q] <= f + FW'(1);
        end else if (fill_dn) begin
          fill_r[sel_q] <= f - FW'(1);
        end
        if (head_up) begin
          head_r[sel_q] <= head_inc[SW-1:0];
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign res_status   = out_status_r;
  assign res_job      = out_job_r;
  assign res_src      = out_src_r;
  assign res_stolen   = out_stolen_r;
  assign res_pending  = out_pend_r;
  assign res_all_done = (out_pend_r == 16'd0);

endmodule
